>>> rtl/prq_pkg.sv
// Shared types, constants and helpers for the priority ready-queue scheduler.
package prq_pkg;

    // Queue and field sizes; the result's queue_count field is five bits wide.
    localparam int QUEUE_DEPTH     = 16;
    localparam int PRIORITY_LEVELS = 64;
    localparam int ID_W            = 8;
    localparam int PRIO_W          = 6;
    localparam int KIND_W          = 3;
    localparam int SLICE_W         = 8;
    localparam int CNT_W           = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W           = $clog2(QUEUE_DEPTH);

    localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(4);
    localparam logic [PRIO_W-1:0]  PRIO_MAX    = PRIO_W'(PRIORITY_LEVELS - 1);

    // Event codes carried in the kind field.
    localparam logic [KIND_W-1:0] KIND_TICK     = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_CREATE   = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_WAKE     = KIND_W'(2);
    localparam logic [KIND_W-1:0] KIND_YIELD    = KIND_W'(3);
    localparam logic [KIND_W-1:0] KIND_BLOCK    = KIND_W'(4);
    localparam logic [KIND_W-1:0] KIND_EXIT     = KIND_W'(5);
    localparam logic [KIND_W-1:0] KIND_SET_PRIO = KIND_W'(6);

    // One input transaction.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   task_id;
        logic [PRIO_W-1:0] priority_req;
    } cmd_t;

    // One result transaction.
    typedef struct packed {
        logic [ID_W-1:0]   running_id;
        logic [PRIO_W-1:0] running_priority;
        logic              running_is_idle;
        logic              switched;
        logic              queue_full;
        logic [CNT_W-1:0]  queue_count;
    } result_t;

    // Operations of the ready-queue unit.
    typedef enum logic {
        Q_INSERT,
        Q_POP
    } q_op_t;

    // Request from the sequencer to the ready-queue unit.
    typedef struct packed {
        logic              valid;
        q_op_t             op;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } q_req_t;

    // Status from the ready-queue unit back to the sequencer.
    typedef struct packed {
        logic              busy;
        logic              done;
        logic              full;
        logic [CNT_W-1:0]  count;
        logic [ID_W-1:0]   head_id;
        logic [PRIO_W-1:0] head_prio;
    } q_stat_t;

    // Scheduler sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVENT,
        S_INS_WAIT,
        S_CHECK,
        S_YIELD,
        S_RUN_NEXT,
        S_POP_WAIT,
        S_REQ_WAIT
    } sched_state_t;

    // Saturate a requested priority to the top level.
    function automatic logic [PRIO_W-1:0] clamp_prio(input logic [PRIO_W-1:0] p);
        logic [PRIO_W-1:0] v;
        v = p;
        if (v > PRIO_MAX)
        begin
            v = PRIO_MAX;
        end
        return v;
    endfunction

endpackage

>>> rtl/prq_queue.sv
// Ready queue kept sorted by descending priority, walked one entry per cycle.
module prq_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  prq_pkg::q_req_t req,
    output prq_pkg::q_stat_t stat
);

    logic [prq_pkg::ID_W-1:0]   ids_reg   [prq_pkg::QUEUE_DEPTH];
    logic [prq_pkg::PRIO_W-1:0] prios_reg [prq_pkg::QUEUE_DEPTH];

    logic [prq_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [prq_pkg::CNT_W-1:0]  k_reg, k_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic                       full_reg, full_next;
    prq_pkg::q_op_t             op_reg, op_next;
    logic [prq_pkg::ID_W-1:0]   new_id_reg, new_id_next;
    logic [prq_pkg::PRIO_W-1:0] new_prio_reg, new_prio_next;

    logic [prq_pkg::IDX_W-1:0]  k_idx;
    logic [prq_pkg::IDX_W-1:0]  rd_idx;
    logic [prq_pkg::ID_W-1:0]   rd_id;
    logic [prq_pkg::PRIO_W-1:0] rd_prio;
    logic                       wr_en;
    logic [prq_pkg::IDX_W-1:0]  wr_idx;
    logic [prq_pkg::ID_W-1:0]   wr_id;
    logic [prq_pkg::PRIO_W-1:0] wr_prio;

    // The walk pointer never reaches the depth while it addresses an entry.
    assign k_idx = k_reg[prq_pkg::IDX_W-1:0];

    // Single read port: the entry below the pointer for inserts, at it for pops.
    assign rd_idx  = (op_reg == prq_pkg::Q_INSERT) ? (k_idx - 1'b1) : k_idx;
    assign rd_id   = ids_reg[rd_idx];
    assign rd_prio = prios_reg[rd_idx];

    // Walk sequencer with one shared compare per cycle.
    always_comb
    begin
        count_next    = count_reg;
        k_next        = k_reg;
        busy_next     = busy_reg;
        done_next     = 1'b0;
        full_next     = 1'b0;
        op_next       = op_reg;
        new_id_next   = new_id_reg;
        new_prio_next = new_prio_reg;
        wr_en         = 1'b0;
        wr_idx        = k_idx;
        wr_id         = new_id_reg;
        wr_prio       = new_prio_reg;

        if (!busy_reg)
        begin
            if (req.valid)
            begin
                unique case (req.op)
                    prq_pkg::Q_INSERT:
                    begin
                        if (count_reg == prq_pkg::CNT_W'(prq_pkg::QUEUE_DEPTH))
                        begin
                            done_next = 1'b1;
                            full_next = 1'b1;
                        end
                        else
                        begin
                            busy_next     = 1'b1;
                            op_next       = prq_pkg::Q_INSERT;
                            k_next        = count_reg;
                            new_id_next   = req.id;
                            new_prio_next = req.prio;
                        end
                    end
                    prq_pkg::Q_POP:
                    begin
                        busy_next = 1'b1;
                        op_next   = prq_pkg::Q_POP;
                        k_next    = prq_pkg::CNT_W'(1);
                    end
                    default:
                    begin
                        busy_next = 1'b0;
                    end
                endcase
            end
        end
        else
        begin
            unique case (op_reg)
                prq_pkg::Q_INSERT:
                begin
                    // Move lower-priority entries up until the slot is found.
                    if (k_reg != '0 && rd_prio < new_prio_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_idx  = k_idx;
                        wr_id   = rd_id;
                        wr_prio = rd_prio;
                        k_next  = k_reg - 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_idx     = k_idx;
                        count_next = count_reg + 1'b1;
                        busy_next  = 1'b0;
                        done_next  = 1'b1;
                    end
                end
                prq_pkg::Q_POP:
                begin
                    // Shift every entry one place toward the head.
                    if (k_reg < count_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_idx  = k_idx - 1'b1;
                        wr_id   = rd_id;
                        wr_prio = rd_prio;
                        k_next  = k_reg + 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        busy_next  = 1'b0;
                        done_next  = 1'b1;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            full_reg  <= 1'b0;
            op_reg    <= prq_pkg::Q_INSERT;
            k_reg     <= '0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            full_reg  <= full_next;
            op_reg    <= op_next;
            k_reg     <= k_next;
        end
    end

    // Payload registers and queue entries.
    always_ff @(posedge clk)
    begin
        new_id_reg   <= new_id_next;
        new_prio_reg <= new_prio_next;
        if (wr_en)
        begin
            ids_reg[wr_idx]   <= wr_id;
            prios_reg[wr_idx] <= wr_prio;
        end
    end

    // Status toward the sequencer; the head is always entry zero.
    always_comb
    begin
        stat.busy      = busy_reg;
        stat.done      = done_reg;
        stat.full      = full_reg;
        stat.count     = count_reg;
        stat.head_id   = ids_reg[0];
        stat.head_prio = prios_reg[0];
    end

endmodule

>>> rtl/priority_ready_queue_scheduler_core.sv
// Top level of the priority ready-queue scheduler: event sequencer and running task.
//
// A transaction is taken when start is high and busy is low; its result appears on
// result for exactly one cycle with result_valid, and busy drops in that same cycle.
// The receiver cannot hold a result off, so it must take it in that cycle. An unused
// event code, an ignored set-priority and a tick that forces no yield report straight
// from the event state; a set-priority that changes the running priority without
// preemption and a block or exit on an empty queue report from the check or run-next
// state, without the queue. Inserts and pops go through the ready-queue unit, which
// moves one of the 16 entries per cycle through a single priority compare, so a wake,
// a create, a block or exit and a yield that requeues the running task take longer the
// more entries they walk; a wake into a full queue is refused by the unit at once. The
// longest event is a create that preempts the running task with 15 entries already
// queued. The slice length register is written with cfg_we and cfg_wdata; the user
// must write it only while busy is low, as the block itself does not enforce this.
module priority_ready_queue_scheduler_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  prq_pkg::cmd_t                cmd,
    output logic                         result_valid,
    output prq_pkg::result_t             result,
    input  logic                         cfg_we,
    input  logic [prq_pkg::SLICE_W-1:0]  cfg_wdata
);

    prq_pkg::sched_state_t state_reg, state_next;

    logic [prq_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [prq_pkg::ID_W-1:0]    id_reg, id_next;
    logic [prq_pkg::PRIO_W-1:0]  prio_reg, prio_next;
    logic [prq_pkg::ID_W-1:0]    cur_id_reg, cur_id_next;
    logic [prq_pkg::PRIO_W-1:0]  cur_prio_reg, cur_prio_next;
    logic                        cur_idle_reg, cur_idle_next;
    logic [prq_pkg::SLICE_W-1:0] slice_reg, slice_next;
    logic [prq_pkg::SLICE_W-1:0] slice_limit_reg;
    logic [prq_pkg::ID_W-1:0]    swap_id_reg, swap_id_next;
    logic [prq_pkg::PRIO_W-1:0]  swap_prio_reg, swap_prio_next;
    logic                        requeue_reg, requeue_next;
    logic                        switched_reg, switched_next;
    logic                        full_reg, full_next;
    prq_pkg::result_t            result_reg, result_next;
    logic                        result_valid_reg, result_valid_next;
    logic                        report;

    prq_pkg::q_req_t             q_req;
    prq_pkg::q_stat_t            q_stat;

    logic [prq_pkg::SLICE_W-1:0] slice_inc;
    logic [prq_pkg::PRIO_W-1:0]  run_prio;
    logic                        head_beats;

    // Ready-queue unit.
    prq_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (q_req),
        .stat  (q_stat)
    );

    // Saturating slice count and the preemption test against the running task.
    assign slice_inc  = (slice_reg == '1) ? slice_reg : (slice_reg + 1'b1);
    assign run_prio   = cur_idle_reg ? '0 : cur_prio_reg;
    assign head_beats = (q_stat.count != '0) && (q_stat.head_prio > run_prio);

    // Next state and outputs of the event sequencer.
    always_comb
    begin
        state_next        = state_reg;
        kind_next         = kind_reg;
        id_next           = id_reg;
        prio_next         = prio_reg;
        cur_id_next       = cur_id_reg;
        cur_prio_next     = cur_prio_reg;
        cur_idle_next     = cur_idle_reg;
        slice_next        = slice_reg;
        swap_id_next      = swap_id_reg;
        swap_prio_next    = swap_prio_reg;
        requeue_next      = requeue_reg;
        switched_next     = switched_reg;
        full_next         = full_reg;
        report            = 1'b0;
        q_req.valid       = 1'b0;
        q_req.op          = prq_pkg::Q_INSERT;
        q_req.id          = id_reg;
        q_req.prio        = prio_reg;

        unique case (state_reg)
            prq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    kind_next     = cmd.kind;
                    id_next       = cmd.task_id;
                    prio_next     = prq_pkg::clamp_prio(cmd.priority_req);
                    switched_next = 1'b0;
                    full_next     = 1'b0;
                    state_next    = prq_pkg::S_EVENT;
                end
            end

            prq_pkg::S_EVENT:
            begin
                unique case (kind_reg)
                    prq_pkg::KIND_TICK:
                    begin
                        slice_next = slice_inc;
                        if (slice_inc >= slice_limit_reg)
                        begin
                            state_next = prq_pkg::S_YIELD;
                        end
                        else
                        begin
                            report     = 1'b1;
                            state_next = prq_pkg::S_IDLE;
                        end
                    end
                    prq_pkg::KIND_CREATE,
                    prq_pkg::KIND_WAKE:
                    begin
                        q_req.valid = 1'b1;
                        state_next  = prq_pkg::S_INS_WAIT;
                    end
                    prq_pkg::KIND_YIELD:
                    begin
                        state_next = prq_pkg::S_YIELD;
                    end
                    prq_pkg::KIND_BLOCK,
                    prq_pkg::KIND_EXIT:
                    begin
                        state_next = prq_pkg::S_RUN_NEXT;
                    end
                    prq_pkg::KIND_SET_PRIO:
                    begin
                        if (!cur_idle_reg && prio_reg != cur_prio_reg)
                        begin
                            cur_prio_next = prio_reg;
                            state_next    = prq_pkg::S_CHECK;
                        end
                        else
                        begin
                            report     = 1'b1;
                            state_next = prq_pkg::S_IDLE;
                        end
                    end
                    default:
                    begin
                        report     = 1'b1;
                        state_next = prq_pkg::S_IDLE;
                    end
                endcase
            end

            prq_pkg::S_INS_WAIT:
            begin
                if (q_stat.done)
                begin
                    full_next = q_stat.full;
                    if (kind_reg == prq_pkg::KIND_CREATE)
                    begin
                        state_next = prq_pkg::S_CHECK;
                    end
                    else
                    begin
                        report     = 1'b1;
                        state_next = prq_pkg::S_IDLE;
                    end
                end
            end

            prq_pkg::S_CHECK:
            begin
                if (head_beats)
                begin
                    state_next = prq_pkg::S_YIELD;
                end
                else
                begin
                    report     = 1'b1;
                    state_next = prq_pkg::S_IDLE;
                end
            end

            prq_pkg::S_YIELD:
            begin
                // The running task steps aside only for a head of equal or higher rank.
                switched_next = 1'b1;
                if (cur_idle_reg)
                begin
                    state_next = prq_pkg::S_RUN_NEXT;
                end
                else
                begin
                    slice_next = '0;
                    if (q_stat.count == '0 || q_stat.head_prio < cur_prio_reg)
                    begin
                        report     = 1'b1;
                        state_next = prq_pkg::S_IDLE;
                    end
                    else
                    begin
                        swap_id_next   = cur_id_reg;
                        swap_prio_next = cur_prio_reg;
                        cur_id_next    = q_stat.head_id;
                        cur_prio_next  = q_stat.head_prio;
                        requeue_next   = 1'b1;
                        q_req.valid    = 1'b1;
                        q_req.op       = prq_pkg::Q_POP;
                        state_next     = prq_pkg::S_POP_WAIT;
                    end
                end
            end

            prq_pkg::S_RUN_NEXT:
            begin
                // The head takes over, or the processor goes idle.
                switched_next = 1'b1;
                slice_next    = '0;
                if (q_stat.count != '0)
                begin
                    cur_id_next   = q_stat.head_id;
                    cur_prio_next = q_stat.head_prio;
                    cur_idle_next = 1'b0;
                    requeue_next  = 1'b0;
                    q_req.valid   = 1'b1;
                    q_req.op      = prq_pkg::Q_POP;
                    state_next    = prq_pkg::S_POP_WAIT;
                end
                else
                begin
                    cur_id_next   = '0;
                    cur_prio_next = '0;
                    cur_idle_next = 1'b1;
                    report        = 1'b1;
                    state_next    = prq_pkg::S_IDLE;
                end
            end

            prq_pkg::S_POP_WAIT:
            begin
                if (q_stat.done)
                begin
                    if (requeue_reg)
                    begin
                        q_req.valid = 1'b1;
                        q_req.op    = prq_pkg::Q_INSERT;
                        q_req.id    = swap_id_reg;
                        q_req.prio  = swap_prio_reg;
                        state_next  = prq_pkg::S_REQ_WAIT;
                    end
                    else
                    begin
                        report     = 1'b1;
                        state_next = prq_pkg::S_IDLE;
                    end
                end
            end

            prq_pkg::S_REQ_WAIT:
            begin
                if (q_stat.done)
                begin
                    report     = 1'b1;
                    state_next = prq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = prq_pkg::S_IDLE;
            end
        endcase
    end

    // Result transaction built from the state that the event leaves behind.
    always_comb
    begin
        result_valid_next = report;
        result_next       = result_reg;
        if (report)
        begin
            result_next.running_id       = cur_idle_next ? '0 : cur_id_next;
            result_next.running_priority = cur_idle_next ? '0 : cur_prio_next;
            result_next.running_is_idle  = cur_idle_next;
            result_next.switched         = switched_next;
            result_next.queue_full       = full_next;
            result_next.queue_count      = q_stat.count;
        end
    end

    // Sequencer and scheduler state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= prq_pkg::S_IDLE;
            cur_id_reg       <= '0;
            cur_prio_reg     <= '0;
            cur_idle_reg     <= 1'b1;
            slice_reg        <= '0;
            requeue_reg      <= 1'b0;
            switched_reg     <= 1'b0;
            full_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cur_id_reg       <= cur_id_next;
            cur_prio_reg     <= cur_prio_next;
            cur_idle_reg     <= cur_idle_next;
            slice_reg        <= slice_next;
            requeue_reg      <= requeue_next;
            switched_reg     <= switched_next;
            full_reg         <= full_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Slice length configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_limit_reg <= prq_pkg::SLICE_RESET;
        end
        else if (cfg_we)
        begin
            slice_limit_reg <= cfg_wdata;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        id_reg        <= id_next;
        prio_reg      <= prio_next;
        swap_id_reg   <= swap_id_next;
        swap_prio_reg <= swap_prio_next;
        result_reg    <= result_next;
    end

    assign busy         = (state_reg != prq_pkg::S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> rtl/prq_checker.sv
// Port-level checker for the scheduler core and its bind to the top level.
module prq_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             result_valid,
    input prq_pkg::result_t result
);

    // An accepted transaction keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // Busy ends exactly when the result of the transaction is shown.
    a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("busy dropped without a result");

    // A result is never shown while a transaction is still in progress.
    a_result_free: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy && !$past(result_valid))
        else $error("result shown while busy or repeated");

    // An idle processor reports a zero id and priority.
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.running_is_idle |->
            result.running_id == '0 && result.running_priority == '0)
        else $error("idle result carries a task");

    // The queue never reports more entries than it holds.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.queue_count <= prq_pkg::CNT_W'(prq_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

bind priority_ready_queue_scheduler_core prq_checker u_prq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

>>> sim/tb_priority_ready_queue_scheduler_core.sv
// Self-checking testbench for the priority ready-queue scheduler core.
module tb_priority_ready_queue_scheduler_core;
    import prq_pkg::*;

    // The event code that the block leaves unused; it must only report status.
    localparam logic [KIND_W-1:0] KIND_UNUSED = KIND_W'(7);
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 50;
    localparam int PHASE_ITEMS   = 240;
    localparam int NUM_PHASES    = 6;

    // Scoreboard: mirrors the scheduler state and holds the status each event should report.
    class sched_scoreboard;
        logic [ID_W-1:0]    ready_id [QUEUE_DEPTH];
        logic [PRIO_W-1:0]  ready_prio [QUEUE_DEPTH];
        int                 ready_len;
        logic [ID_W-1:0]    run_id;
        logic [PRIO_W-1:0]  run_prio;
        bit                 run_idle;
        logic [SLICE_W-1:0] slice_used;
        logic [SLICE_W-1:0] slice_len;
        result_t            status_due[$];
        int                 errors;

        function new();
            ready_len  = 0;
            run_id     = '0;
            run_prio   = '0;
            run_idle   = 1'b1;
            slice_used = '0;
            slice_len  = SLICE_RESET;
            errors     = 0;
        endfunction

        function void set_slice(logic [SLICE_W-1:0] v);
            slice_len = v;
        endfunction

        // Ordered insert behind every entry of equal or higher priority.
        function bit enqueue_ready(logic [ID_W-1:0] id, logic [PRIO_W-1:0] pr);
            int pos;
            int k;
            if (ready_len >= QUEUE_DEPTH)
            begin
                return 1'b0;
            end
            pos = 0;
            while (pos < ready_len && ready_prio[pos] >= pr)
            begin
                pos++;
            end
            for (k = ready_len; k > pos; k--)
            begin
                ready_id[k]   = ready_id[k-1];
                ready_prio[k] = ready_prio[k-1];
            end
            ready_id[pos]   = id;
            ready_prio[pos] = pr;
            ready_len++;
            return 1'b1;
        endfunction

        // Take the head; only called with a non-empty queue.
        function void dequeue_ready(output logic [ID_W-1:0] id, output logic [PRIO_W-1:0] pr);
            int k;
            id = ready_id[0];
            pr = ready_prio[0];
            for (k = 1; k < ready_len; k++)
            begin
                ready_id[k-1]   = ready_id[k];
                ready_prio[k-1] = ready_prio[k];
            end
            ready_len--;
        endfunction

        // The running task leaves; the head or idle takes over.
        function void dispatch_next();
            if (ready_len > 0)
            begin
                dequeue_ready(run_id, run_prio);
                run_idle = 1'b0;
            end
            else
            begin
                run_id   = '0;
                run_prio = '0;
                run_idle = 1'b1;
            end
            slice_used = '0;
        endfunction

        // The running task goes back into the queue unless it outranks the head.
        function void requeue_running();
            logic [ID_W-1:0]   sid;
            logic [PRIO_W-1:0] spr;
            if (run_idle)
            begin
                dispatch_next();
                return;
            end
            slice_used = '0;
            if (ready_len == 0 || ready_prio[0] < run_prio)
            begin
                return;
            end
            sid = run_id;
            spr = run_prio;
            dequeue_ready(run_id, run_prio);
            void'(enqueue_ready(sid, spr));
        endfunction

        function bit head_outranks();
            logic [PRIO_W-1:0] cur;
            cur = run_idle ? '0 : run_prio;
            return ready_len > 0 && ready_prio[0] > cur;
        endfunction

        // Apply one accepted event and queue the status it must report.
        function void note_event(cmd_t c);
            bit                sw;
            bit                full;
            logic [PRIO_W-1:0] pr;
            result_t           r;
            sw   = 1'b0;
            full = 1'b0;
            pr   = (c.priority_req > PRIO_MAX) ? PRIO_MAX : c.priority_req;
            case (c.kind)
                KIND_TICK:
                begin
                    if (slice_used != '1)
                    begin
                        slice_used++;
                    end
                    if (slice_used >= slice_len)
                    begin
                        requeue_running();
                        sw = 1'b1;
                    end
                end
                KIND_CREATE:
                begin
                    full = !enqueue_ready(c.task_id, pr);
                    if (head_outranks())
                    begin
                        requeue_running();
                        sw = 1'b1;
                    end
                end
                KIND_WAKE:
                begin
                    full = !enqueue_ready(c.task_id, pr);
                end
                KIND_YIELD:
                begin
                    requeue_running();
                    sw = 1'b1;
                end
                KIND_BLOCK, KIND_EXIT:
                begin
                    dispatch_next();
                    sw = 1'b1;
                end
                KIND_SET_PRIO:
                begin
                    if (!run_idle && pr != run_prio)
                    begin
                        run_prio = pr;
                        if (head_outranks())
                        begin
                            requeue_running();
                            sw = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            r.running_id       = run_idle ? '0 : run_id;
            r.running_priority = run_idle ? '0 : run_prio;
            r.running_is_idle  = run_idle;
            r.switched         = sw;
            r.queue_full       = full;
            r.queue_count      = CNT_W'(ready_len);
            status_due.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        // Compare a result transaction with the oldest expected status.
        function void check_status(result_t got);
            result_t want;
            if (status_due.size() == 0)
            begin
                errors++;
                $display("%0t: result with no event pending: expected none, actual id %0d",
                         $time, got.running_id);
                return;
            end
            want = status_due.pop_front();
            compare_field("running_id", 16'(want.running_id), 16'(got.running_id));
            compare_field("running_priority", 16'(want.running_priority),
                          16'(got.running_priority));
            compare_field("running_is_idle", 16'(want.running_is_idle),
                          16'(got.running_is_idle));
            compare_field("switched", 16'(want.switched), 16'(got.switched));
            compare_field("queue_full", 16'(want.queue_full), 16'(got.queue_full));
            compare_field("queue_count", 16'(want.queue_count), 16'(got.queue_count));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    cmd_t               cmd;
    logic               result_valid;
    result_t            result;
    logic               cfg_we;
    logic [SLICE_W-1:0] cfg_wdata;

    sched_scoreboard    sb;
    int                 accepted_total = 0;

    priority_ready_queue_scheduler_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    // Clock with a period of 20.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Monitor: register writes, accepted events and results, all seen at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                sb.set_slice(cfg_wdata);
            end
            if (start && !busy)
            begin
                sb.note_event(cmd);
                accepted_total <= accepted_total + 1;
            end
            if (result_valid)
            begin
                sb.check_status(result);
            end
        end
    end

    function automatic cmd_t make_event(logic [KIND_W-1:0] k, logic [ID_W-1:0] id,
                                        logic [PRIO_W-1:0] pr);
        cmd_t c;
        c.kind         = k;
        c.task_id      = id;
        c.priority_req = pr;
        return c;
    endfunction

    // Priorities lean toward the extremes and one narrow band so that ties are common.
    function automatic logic [PRIO_W-1:0] pick_prio();
        case ($urandom_range(3))
            0: return '0;
            1: return PRIO_MAX;
            2: return PRIO_W'($urandom_range(33, 30));
            default: return PRIO_W'($urandom_range(63));
        endcase
    endfunction

    // Random event shaped by the current burst: mixed, filling, draining or a run of ticks.
    function automatic cmd_t random_event(int mode);
        int                roll;
        logic [KIND_W-1:0] k;
        roll = $urandom_range(99);
        case (mode)
            1:
            begin
                k = (roll < 45) ? KIND_WAKE : (roll < 80) ? KIND_CREATE :
                    (roll < 90) ? KIND_TICK : KIND_YIELD;
            end
            2:
            begin
                k = (roll < 35) ? KIND_BLOCK : (roll < 60) ? KIND_EXIT :
                    (roll < 80) ? KIND_YIELD : KIND_TICK;
            end
            3:
            begin
                k = (roll < 92) ? KIND_TICK : KIND_SET_PRIO;
            end
            default:
            begin
                k = (roll < 25) ? KIND_TICK : (roll < 40) ? KIND_CREATE :
                    (roll < 55) ? KIND_WAKE : (roll < 65) ? KIND_YIELD :
                    (roll < 72) ? KIND_BLOCK : (roll < 78) ? KIND_EXIT :
                    (roll < 96) ? KIND_SET_PRIO : KIND_UNUSED;
            end
        endcase
        return make_event(k, ID_W'($urandom_range(255)), pick_prio());
    endfunction

    // Offer one transaction at a falling edge and hold it until the block takes it.
    task automatic send_event(cmd_t c);
        int seen;
        start <= 1'b1;
        cmd   <= c;
        seen  = accepted_total;
        do
        begin
            @(negedge clk);
        end
        while (accepted_total == seen);
    endtask

    // Sender idles for a random number of cycles.
    task automatic idle_gap(int pct);
        while ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
    endtask

    // Stop sending until every expected result has come and the block has settled.
    task automatic drain();
        start <= 1'b0;
        while (sb.status_due.size() != 0 || busy)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_slice(logic [SLICE_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Timeout guard.
    initial
    begin
        #20000000;
        $display("** priority_ready_queue_scheduler_core: FAILED **");
        $finish;
    end

    // Main sequence: reset, directed events, then random phases with different slices.
    initial
    begin
        int                 i;
        int                 p;
        int                 n;
        int                 mode;
        int                 len;
        int                 pct;
        logic [SLICE_W-1:0] slice;
        sb             = new();
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        cmd            = '0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: idle corner cases first.
        send_event(make_event(KIND_UNUSED, 8'hFF, 6'h3F));
        send_event(make_event(KIND_YIELD, 8'h00, 6'h00));
        send_event(make_event(KIND_SET_PRIO, 8'h00, 6'h3F));
        // A top-priority create preempts idle; setting the same priority changes nothing.
        send_event(make_event(KIND_CREATE, 8'hFF, 6'h3F));
        send_event(make_event(KIND_SET_PRIO, 8'hFF, 6'h3F));
        send_event(make_event(KIND_WAKE, 8'h00, 6'h00));
        // An equal-priority create does not preempt, but a yield hands over to it.
        send_event(make_event(KIND_CREATE, 8'h55, 6'h3F));
        send_event(make_event(KIND_YIELD, 8'h00, 6'h00));
        send_event(make_event(KIND_SET_PRIO, 8'h00, 6'h00));
        // Fill the queue, then overflow it with a create.
        for (i = 0; i < QUEUE_DEPTH - 2; i++)
        begin
            send_event(make_event(KIND_WAKE, ID_W'(8'h10 + i), PRIO_W'(i * 4 + 3)));
        end
        send_event(make_event(KIND_CREATE, 8'hAA, 6'h2A));
        // Yield on a full queue: first the running task outranks the head, then it does not.
        send_event(make_event(KIND_YIELD, 8'h00, 6'h00));
        send_event(make_event(KIND_SET_PRIO, 8'h00, 6'h00));
        send_event(make_event(KIND_EXIT, 8'h00, 6'h00));
        drain();

        // Random phases, each with its own slice length and sender idling.
        for (p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: begin slice = 8'd1;   pct = 0;  end
                1: begin slice = 8'd255; pct = 86; end
                2: begin slice = 8'd0;   pct = 0;  end
                3: begin slice = SLICE_W'($urandom_range(16, 2)); pct = 37; end
                4: begin slice = 8'd3;   pct = 86; end
                default: begin slice = SLICE_W'($urandom_range(255, 1)); pct = 37; end
            endcase
            write_slice(slice);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                mode = $urandom_range(3);
                if (mode == 3)
                begin
                    len = ($urandom_range(3) == 0) ? int'(slice) + 2 : $urandom_range(40, 5);
                end
                else
                begin
                    len = $urandom_range(24, 4);
                end
                for (i = 0; i < len; i++)
                begin
                    send_event(random_event(mode));
                    idle_gap(pct);
                    n++;
                end
            end
            drain();
        end

        if (sb.errors == 0 && sb.status_due.size() == 0)
        begin
            $display("** priority_ready_queue_scheduler_core: PASSED **");
        end
        else
        begin
            $display("** priority_ready_queue_scheduler_core: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/prq_pkg.sv
rtl/prq_queue.sv
rtl/priority_ready_queue_scheduler_core.sv
rtl/prq_checker.sv
sim/tb_priority_ready_queue_scheduler_core.sv
